### design/cpu_8bit_alu_with_flags_unit_assert.svh
// assertion macros for the 8-bit alu with flags
`ifndef CPU_8BIT_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define CPU_8BIT_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ALU8F_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define ALU8F_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/alu8f_pkg.sv
// shared types and operation codes for the 8-bit alu with flags
package alu8f_pkg;

  localparam int MODE_W = 5;
  localparam int DATA_W = 8;
  localparam int BIT_W  = 3;
  localparam int FLAG_W = 4;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [MODE_W-1:0] MODE_ADD  = 5'd0;
  localparam logic [MODE_W-1:0] MODE_ADC  = 5'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 5'd2;
  localparam logic [MODE_W-1:0] MODE_SBC  = 5'd3;
  localparam logic [MODE_W-1:0] MODE_AND  = 5'd4;
  localparam logic [MODE_W-1:0] MODE_OR   = 5'd5;
  localparam logic [MODE_W-1:0] MODE_XOR  = 5'd6;
  localparam logic [MODE_W-1:0] MODE_CP   = 5'd7;
  localparam logic [MODE_W-1:0] MODE_INC  = 5'd8;
  localparam logic [MODE_W-1:0] MODE_DEC  = 5'd9;
  localparam logic [MODE_W-1:0] MODE_DAA  = 5'd10;
  localparam logic [MODE_W-1:0] MODE_CPL  = 5'd11;
  localparam logic [MODE_W-1:0] MODE_CCF  = 5'd12;
  localparam logic [MODE_W-1:0] MODE_SCF  = 5'd13;
  localparam logic [MODE_W-1:0] MODE_RLCA = 5'd14;
  localparam logic [MODE_W-1:0] MODE_RLA  = 5'd15;
  localparam logic [MODE_W-1:0] MODE_RRCA = 5'd16;
  localparam logic [MODE_W-1:0] MODE_RRA  = 5'd17;
  localparam logic [MODE_W-1:0] MODE_RLC  = 5'd18;
  localparam logic [MODE_W-1:0] MODE_RL   = 5'd19;
  localparam logic [MODE_W-1:0] MODE_RRC  = 5'd20;
  localparam logic [MODE_W-1:0] MODE_RR   = 5'd21;
  localparam logic [MODE_W-1:0] MODE_SLA  = 5'd22;
  localparam logic [MODE_W-1:0] MODE_SRA  = 5'd23;
  localparam logic [MODE_W-1:0] MODE_SRL  = 5'd24;
  localparam logic [MODE_W-1:0] MODE_SWAP = 5'd25;
  localparam logic [MODE_W-1:0] MODE_BIT  = 5'd26;
  localparam logic [MODE_W-1:0] MODE_RES  = 5'd27;
  localparam logic [MODE_W-1:0] MODE_SET  = 5'd28;

  // decimal adjust constants
  localparam logic [DATA_W-1:0] DAA_LO_ADJ = 8'h06;
  localparam logic [DATA_W-1:0] DAA_HI_ADJ = 8'h60;
  localparam logic [DATA_W-1:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0]        DAA_LO_MAX = 4'h9;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] acc_value;
    logic [DATA_W-1:0] operand;
    logic [BIT_W-1:0]  bit_index;
    logic [FLAG_W-1:0] flags_in;
  } alu8f_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
  } alu8f_rsp_t;

endpackage

### design/cpu_8bit_alu_with_flags_unit.sv
// top level: input register, alu datapath, result register
// One transaction is accepted per clock and one result leaves per clock while no
// stall holds the flow. Each operation is captured in the input register, passes
// through the combinational alu datapath and is loaded into the result register,
// where it is held until taken. A stall on the result side holds the result
// register and a full input register; the input side stalls only when the input
// register is full and cannot move forward. Unused operation codes return the
// accumulator and the incoming flags unchanged.
module cpu_8bit_alu_with_flags_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  alu8f_pkg::alu8f_req_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output alu8f_pkg::alu8f_rsp_t rsp
);
  import alu8f_pkg::*;

  logic       held_valid;
  alu8f_req_t held;
  alu8f_rsp_t alu_out;
  logic       advance;

  // result register can take a new value when empty or being drained
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held <= req;
    end
  end

  alu8f_core u_core (
    .req (held),
    .rsp (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      rsp <= alu_out;
    end
  end

`include "cpu_8bit_alu_with_flags_unit_assert.svh"

  `ALU8F_ASSERT_NOW(a_stall_needs_item, req_stall, held_valid, "stall with empty input register")
  `ALU8F_ASSERT_NEXT(a_held_kept, held_valid && !advance, held_valid && $stable(held), "input lost")
  `ALU8F_ASSERT_NEXT(a_result_loaded, held_valid && advance, rsp_valid, "result not loaded")

endmodule

### design/alu8f_core.sv
// single-pass combinational alu datapath: result byte and new flags
module alu8f_core (
  input  alu8f_pkg::alu8f_req_t req,
  output alu8f_pkg::alu8f_rsp_t rsp
);
  import alu8f_pkg::*;

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [FLAG_W-1:0] f;
  logic              c;
  logic              cin;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   diff;
  logic [4:0]        half_diff;
  logic [DATA_W-1:0] bit_mask;
  logic [DATA_W-1:0] daa_adj;
  logic              daa_lo;
  logic              daa_hi;
  logic [DATA_W-1:0] r;
  logic [FLAG_W-1:0] nf;

  assign a = req.acc_value;
  assign b = req.operand;
  assign f = req.flags_in;
  assign c = f[FLAG_C];
  assign bit_mask = DATA_W'(1) << req.bit_index;

  // shared adder and subtractor, carry used only by adc and sbc
  always_comb begin
    cin = ((req.mode == MODE_ADC) || (req.mode == MODE_SBC)) ? c : 1'b0;
    sum = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
    diff = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cin};
    half_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
  end

  // decimal adjust amount depends on whether the last op was a subtraction
  always_comb begin
    if (f[FLAG_N]) begin
      daa_lo = f[FLAG_H];
      daa_hi = c;
    end else begin
      daa_lo = f[FLAG_H] || (a[3:0] > DAA_LO_MAX);
      daa_hi = c || (a > DAA_HI_MAX);
    end
    daa_adj = (daa_lo ? DAA_LO_ADJ : '0) | (daa_hi ? DAA_HI_ADJ : '0);
  end

  always_comb begin
    r  = a;
    nf = f;
    case (req.mode)
      MODE_ADD, MODE_ADC: begin
        r  = sum[DATA_W-1:0];
        nf = {sum[DATA_W-1:0] == '0, 1'b0, a[4] ^ b[4] ^ sum[4], sum[DATA_W]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r  = (req.mode == MODE_CP) ? a : diff[DATA_W-1:0];
        nf = {diff[DATA_W-1:0] == '0, 1'b1, half_diff[4], diff[DATA_W]};
      end
      MODE_AND: begin
        r  = a & b;
        nf = {(a & b) == '0, 1'b0, 1'b1, 1'b0};
      end
      MODE_OR: begin
        r  = a | b;
        nf = {(a | b) == '0, 3'b000};
      end
      MODE_XOR: begin
        r  = a ^ b;
        nf = {(a ^ b) == '0, 3'b000};
      end
      MODE_INC: begin
        r  = b + DATA_W'(1);
        nf = {b == '1, 1'b0, b[3:0] == 4'hf, c};
      end
      MODE_DEC: begin
        r  = b - DATA_W'(1);
        nf = {b == DATA_W'(1), 1'b1, b[3:0] == 4'h0, c};
      end
      MODE_DAA: begin
        r  = f[FLAG_N] ? (a - daa_adj) : (a + daa_adj);
        nf = {r == '0, f[FLAG_N], 1'b0, f[FLAG_N] ? c : daa_hi};
      end
      MODE_CPL: begin
        r  = ~a;
        nf = {f[FLAG_Z], 1'b1, 1'b1, c};
      end
      MODE_CCF: nf = {f[FLAG_Z], 2'b00, ~c};
      MODE_SCF: nf = {f[FLAG_Z], 2'b00, 1'b1};
      // accumulator rotates always clear zero
      MODE_RLCA: begin
        r  = {a[DATA_W-2:0], a[DATA_W-1]};
        nf = {3'b000, a[DATA_W-1]};
      end
      MODE_RLA: begin
        r  = {a[DATA_W-2:0], c};
        nf = {3'b000, a[DATA_W-1]};
      end
      MODE_RRCA: begin
        r  = {a[0], a[DATA_W-1:1]};
        nf = {3'b000, a[0]};
      end
      MODE_RRA: begin
        r  = {c, a[DATA_W-1:1]};
        nf = {3'b000, a[0]};
      end
      MODE_RLC: begin
        r  = {b[DATA_W-2:0], b[DATA_W-1]};
        nf = {r == '0, 2'b00, b[DATA_W-1]};
      end
      MODE_RL: begin
        r  = {b[DATA_W-2:0], c};
        nf = {r == '0, 2'b00, b[DATA_W-1]};
      end
      MODE_RRC: begin
        r  = {b[0], b[DATA_W-1:1]};
        nf = {r == '0, 2'b00, b[0]};
      end
      MODE_RR: begin
        r  = {c, b[DATA_W-1:1]};
        nf = {r == '0, 2'b00, b[0]};
      end
      MODE_SLA: begin
        r  = {b[DATA_W-2:0], 1'b0};
        nf = {r == '0, 2'b00, b[DATA_W-1]};
      end
      MODE_SRA: begin
        r  = {b[DATA_W-1], b[DATA_W-1:1]};
        nf = {r == '0, 2'b00, b[0]};
      end
      MODE_SRL: begin
        r  = {1'b0, b[DATA_W-1:1]};
        nf = {r == '0, 2'b00, b[0]};
      end
      MODE_SWAP: begin
        r  = {b[3:0], b[7:4]};
        nf = {b == '0, 3'b000};
      end
      MODE_BIT: begin
        r  = b;
        nf = {(b & bit_mask) == '0, 1'b0, 1'b1, c};
      end
      MODE_RES: r = b & ~bit_mask;
      MODE_SET: r = b | bit_mask;
      default: begin
        r  = a;
        nf = f;
      end
    endcase
  end

  assign rsp.result    = r;
  assign rsp.flags_out = nf;

endmodule

### verif/alu8f_scoreboard.sv
`timescale 1ns / 100ps
// checker for the 8-bit alu with flags: predicts each transaction and compares the results
module alu8f_scoreboard
  import alu8f_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  alu8f_req_t req,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  alu8f_rsp_t rsp,
  output int         mismatches,
  output int         outstanding,
  output int         compared
);

  alu8f_rsp_t awaited_results [$];

  function automatic alu8f_rsp_t compute_alu(alu8f_req_t op);
    alu8f_rsp_t res;
    logic [7:0] a, b, r, adj;
    logic [3:0] f, nf;
    logic       cy, cin, cout;
    logic [8:0] wide;
    a = op.acc_value;
    b = op.operand;
    f = op.flags_in;
    cy = f[FLAG_C];
    r = a;
    nf = f;
    case (op.mode)
      MODE_ADD, MODE_ADC: begin
        cin = (op.mode == MODE_ADC) & cy;
        wide = a + b + cin;
        r = wide[7:0];
        nf = {r == 8'h00, 1'b0, a[4] ^ b[4] ^ wide[4], wide[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        cin = (op.mode == MODE_SBC) & cy;
        r = a - b - cin;
        nf = {r == 8'h00, 1'b1, {1'b0, a[3:0]} < {1'b0, b[3:0]} + cin,
              {1'b0, a} < {1'b0, b} + cin};
        // compare only sets flags
        if (op.mode == MODE_CP) r = a;
      end
      MODE_AND: begin
        r = a & b;
        nf = {r == 8'h00, 3'b010};
      end
      MODE_OR: begin
        r = a | b;
        nf = {r == 8'h00, 3'b000};
      end
      MODE_XOR: begin
        r = a ^ b;
        nf = {r == 8'h00, 3'b000};
      end
      MODE_INC: begin
        r = b + 8'd1;
        nf = {r == 8'h00, 1'b0, b[3:0] == 4'hF, cy};
      end
      MODE_DEC: begin
        r = b - 8'd1;
        nf = {r == 8'h00, 1'b1, b[3:0] == 4'h0, cy};
      end
      MODE_DAA: begin
        adj = 8'h00;
        cout = cy;
        if (f[FLAG_N]) begin
          // after a subtraction carry is kept
          if (f[FLAG_H]) adj |= 8'h06;
          if (cy) adj |= 8'h60;
          r = a - adj;
        end else begin
          if (f[FLAG_H] || a[3:0] > 4'h9) adj |= 8'h06;
          if (cy || a > 8'h99) begin
            adj |= 8'h60;
            cout = 1'b1;
          end
          r = a + adj;
        end
        nf = {r == 8'h00, f[FLAG_N], 1'b0, cout};
      end
      MODE_CPL: begin
        r = ~a;
        nf = {f[FLAG_Z], 2'b11, cy};
      end
      MODE_CCF: nf = {f[FLAG_Z], 2'b00, ~cy};
      MODE_SCF: nf = {f[FLAG_Z], 3'b001};
      // accumulator rotates always clear zero
      MODE_RLCA: begin
        r = {a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      MODE_RLA: begin
        r = {a[6:0], cy};
        nf = {3'b000, a[7]};
      end
      MODE_RRCA: begin
        r = {a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      MODE_RRA: begin
        r = {cy, a[7:1]};
        nf = {3'b000, a[0]};
      end
      MODE_RLC: begin
        r = {b[6:0], b[7]};
        nf = {r == 8'h00, 2'b00, b[7]};
      end
      MODE_RL: begin
        r = {b[6:0], cy};
        nf = {r == 8'h00, 2'b00, b[7]};
      end
      MODE_RRC: begin
        r = {b[0], b[7:1]};
        nf = {r == 8'h00, 2'b00, b[0]};
      end
      MODE_RR: begin
        r = {cy, b[7:1]};
        nf = {r == 8'h00, 2'b00, b[0]};
      end
      MODE_SLA: begin
        r = {b[6:0], 1'b0};
        nf = {r == 8'h00, 2'b00, b[7]};
      end
      MODE_SRA: begin
        r = {b[7], b[7:1]};
        nf = {r == 8'h00, 2'b00, b[0]};
      end
      MODE_SRL: begin
        r = {1'b0, b[7:1]};
        nf = {r == 8'h00, 2'b00, b[0]};
      end
      MODE_SWAP: begin
        r = {b[3:0], b[7:4]};
        nf = {r == 8'h00, 3'b000};
      end
      MODE_BIT: begin
        r = b;
        nf = {~b[op.bit_index], 2'b01, cy};
      end
      MODE_RES: r = b & ~(8'h01 << op.bit_index);
      MODE_SET: r = b | (8'h01 << op.bit_index);
      default: ;
    endcase
    res.result = r;
    res.flags_out = nf;
    return res;
  endfunction

  always @(posedge clk) begin
    alu8f_rsp_t want;
    if (rst) begin
      awaited_results.delete();
    end else begin
      if (req_valid && !req_stall) awaited_results.push_back(compute_alu(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, got result %h flags %h",
                   $time, rsp.result, rsp.flags_out);
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (rsp.result !== want.result) begin
            mismatches++;
            $display("%0t: result expected %h, got %h", $time, want.result, rsp.result);
          end
          if (rsp.flags_out !== want.flags_out) begin
            mismatches++;
            $display("%0t: flags expected %b, got %b", $time, want.flags_out, rsp.flags_out);
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### verif/cpu_8bit_alu_with_flags_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the 8-bit alu with flags: clock, reset, stimulus and verdict
module cpu_8bit_alu_with_flags_unit_tb;
  import alu8f_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  localparam int RANDOM_OPS = 1720;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         req_valid = 1'b0;
  logic         req_stall;
  alu8f_req_t   req = '0;
  logic         rsp_valid;
  logic         rsp_stall = 1'b0;
  alu8f_rsp_t   rsp;
  int           mismatches;
  int           outstanding;
  int           compared;
  int           burst_left = 0;
  int           ops_sent = 0;
  int           directed_ops = 0;
  stall_style_t stall_style = STALL_NONE;
  int           stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cpu_8bit_alu_with_flags_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  alu8f_scoreboard i_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  // result side backpressure switches to a randomly chosen style when its countdown expires
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
      default:     rsp_stall <= (stall_left % 8 < 3);
    endcase
  end

  // corner bytes for carries, half carries and decimal adjust
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h99, 8'h9A, 8'h80, 8'h01};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic alu8f_req_t random_op();
    alu8f_req_t op;
    // mostly defined operations, some unused codes
    if ($urandom_range(0, 19) == 0) op.mode = 5'($urandom_range(MODE_SET + 1, 2**MODE_W - 1));
    else op.mode = 5'($urandom_range(MODE_ADD, MODE_SET));
    op.acc_value = pick_byte();
    op.operand = pick_byte();
    op.bit_index = 3'($urandom_range(0, 7));
    op.flags_in = 4'($urandom_range(0, 15));
    return op;
  endfunction

  // present one transaction, wait for acceptance, then maybe pause between bursts
  task automatic drive_op(input alu8f_req_t op);
    int gap;
    req <= op;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    alu8f_req_t op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // every operation once plus one unused code
    for (int m = MODE_ADD; m <= MODE_SET + 1; m++) begin
      op.mode = 5'(m);
      op.acc_value = (m % 3 == 0) ? 8'hFF : (m % 3 == 1) ? 8'h9A : 8'h00;
      op.operand = m[0] ? 8'h00 : 8'hFF;
      op.bit_index = m[2:0];
      op.flags_in = m[3:0];
      drive_op(op);
    end
    directed_ops = ops_sent;
    repeat (RANDOM_OPS) drive_op(random_op());
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d alu transactions (%0d directed, rest random) under mixed stalls",
             ops_sent, directed_ops);
    $display("compared %0d results, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results still awaited", outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
